// File: hw/rtl/ort_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ort_pkg
// Shared types, codes and defaults for the outstanding request table.
// ----------------------------------------------------------------------------
package ort_pkg;
    localparam int DEF_TABLE_DEPTH = 256;
    localparam int DEF_SHARE_BITS  = 64;
    localparam logic [7:0]  MAX_ENTRIES_RST = 8'd128;
    localparam logic [15:0] MAX_AGE_RST     = 16'd36;

    localparam logic [2:0] OP_DUP    = 3'd0;
    localparam logic [2:0] OP_RECORD = 3'd1;
    localparam logic [2:0] OP_REMOVE = 3'd2;
    localparam logic [2:0] OP_LOOKUP = 3'd3;
    localparam logic [2:0] OP_TICK   = 3'd4;

    localparam logic REG_MAX_ENTRIES = 1'b0;
    localparam logic REG_MAX_AGE     = 1'b1;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;        // capture request, clear runner-up promotion flag
        logic scan_start;  // reset scan index and clear scan results
        logic scan_step;   // examine one entry
        logic clean_eval;  // decide on eviction of smallest-id entry
        logic ins_commit;  // write record into found or free slot
        logic rem_commit;  // invalidate matched slot
        logic tick;        // advance seconds counter
        logic res_load;    // capture result into output register
    } ort_cmd_t;

    typedef struct packed {
        logic scan_last;   // registered read data is from the final entry
        logic out_full;    // result register holds a result that the output stalls
    } ort_sts_t;
endpackage
`default_nettype wire

// File: hw/rtl/ort_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ort_ctrl
// Sequencer: scan, cleanup and commit phases per operation.
// ----------------------------------------------------------------------------
module ort_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_acc,
    input  wire logic [2:0]      req_type,
    input  wire ort_pkg::ort_sts_t sts,
    output logic                 busy,
    output ort_pkg::ort_cmd_t    cmd
);
    import ort_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_SCAN1  = 8'b0000_0010,
        S_CLEAN1 = 8'b0000_0100,
        S_SCAN2  = 8'b0000_1000,
        S_CLEAN2 = 8'b0001_0000,
        S_COMMIT = 8'b0010_0000,
        S_RESULT = 8'b0100_0000,
        S_WAIT   = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [2:0] op_reg, op_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    op_next  = req_type;
                    cmd.load = 1'b1;
                    case (req_type)
                        OP_DUP, OP_REMOVE, OP_LOOKUP, OP_RECORD:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next = (req_type == OP_RECORD) ? S_SCAN1 : S_SCAN2;
                        end
                        OP_TICK:
                        begin
                            cmd.tick   = 1'b1;
                            state_next = S_RESULT;
                        end
                        default: state_next = S_RESULT;
                    endcase
                end
            end
            // record: cleanup scan before insert
            S_SCAN1:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_CLEAN1;
            end
            S_CLEAN1:
            begin
                cmd.clean_eval = 1'b1;
                cmd.scan_start = 1'b1;
                state_next     = S_SCAN2;
            end
            // key/share scan (plus smallest id for remove and lookup)
            S_SCAN2:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                    state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                case (op_reg)
                    OP_RECORD: begin cmd.ins_commit = 1'b1; state_next = S_RESULT; end
                    OP_REMOVE: begin cmd.rem_commit = 1'b1; state_next = S_CLEAN2; end
                    OP_LOOKUP: state_next = S_CLEAN2;
                    default:   state_next = S_RESULT;
                endcase
            end
            S_CLEAN2:
            begin
                cmd.clean_eval = 1'b1;
                state_next     = S_RESULT;
            end
            S_RESULT:
            begin
                if (!sts.out_full)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
                else
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (!sts.out_full)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= OP_DUP;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/ort_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ort_dp
// Datapath: entry memory, serial scan, cleanup, commit and result register.
// ----------------------------------------------------------------------------
module ort_dp #(
    parameter int TABLE_DEPTH = ort_pkg::DEF_TABLE_DEPTH,
    parameter int SHARE_BITS  = ort_pkg::DEF_SHARE_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ort_pkg::ort_cmd_t cmd,
    output ort_pkg::ort_sts_t      sts,
    input  wire logic [2:0]        req_type,
    input  wire logic signed [31:0] req_id,
    input  wire logic [63:0]       share_in,
    input  wire logic              cfg_we,
    input  wire logic              cfg_idx,
    input  wire logic [15:0]       cfg_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   hit,
    output logic [63:0]            share_out,
    output logic signed [31:0]     age_sec,
    output logic [8:0]             entry_count
);
    import ort_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    // memories (read data registered)
    logic [31:0]         key_mem   [TABLE_DEPTH];
    logic [SHARE_BITS-1:0] share_mem [TABLE_DEPTH];
    logic [31:0]         stamp_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;

    logic [31:0]           rd_key;
    logic [SHARE_BITS-1:0] rd_share;
    logic [31:0]           rd_stamp;
    logic                  rd_valid;
    logic [AW-1:0]         rd_idx;

    logic [AW:0]  idx_reg;        // read address counter, a value equal to depth marks done
    logic         pend_reg;       // registered read data is meaningful
    logic [2:0]   op_reg;
    logic [31:0]  key_reg;
    logic [SHARE_BITS-1:0] shr_reg;
    logic         match_reg;      // key or share found
    logic [AW-1:0] match_idx_reg;
    logic [SHARE_BITS-1:0] mshare_reg;
    logic [31:0]  mstamp_reg;
    logic         free_reg;
    logic [AW-1:0] free_idx_reg;
    logic         best_reg;
    logic [AW-1:0] best_idx_reg;
    logic [31:0]  best_key_reg;
    logic [31:0]  best_stamp_reg;
    logic [31:0]  now_reg;
    logic [CW-1:0] occ_reg;
    logic [7:0]   max_ent_reg;
    logic [15:0]  max_age_reg;
    logic         out_full_reg;

    // After remove of the smallest id the next candidate is the runner-up.
    logic          sec_reg;
    logic [AW-1:0] sec_idx_reg;
    logic [31:0]   sec_key_reg;
    logic [31:0]   sec_stamp_reg;
    logic          rem_best;

    logic          c_valid;
    logic [AW-1:0] c_idx;
    logic [31:0]   c_stamp;
    logic [31:0]   c_age;
    logic          c_evict;
    logic [CW-1:0] occ_after;

    logic        rec_ok;
    logic [AW-1:0] wr_idx;

    assign sts.scan_last = (idx_reg == (AW+1)'(TABLE_DEPTH)) && pend_reg;
    assign sts.out_full  = out_full_reg && out_stall;

    always_ff @(posedge clk)
    begin
        rd_idx   <= idx_reg[AW-1:0];
        rd_key   <= key_mem[idx_reg[AW-1:0]];
        rd_share <= share_mem[idx_reg[AW-1:0]];
        rd_stamp <= stamp_mem[idx_reg[AW-1:0]];
        rd_valid <= valid_reg[idx_reg[AW-1:0]];
        if (cmd.ins_commit && rec_ok)
        begin
            key_mem[wr_idx]   <= key_reg;
            share_mem[wr_idx] <= shr_reg;
            stamp_mem[wr_idx] <= now_reg;
        end
    end

    assign rec_ok = match_reg || free_reg;
    assign wr_idx = match_reg ? match_idx_reg : free_idx_reg;

    assign c_valid = rem_best ? sec_reg : best_reg;
    assign c_idx   = rem_best ? sec_idx_reg : best_idx_reg;
    assign c_stamp = rem_best ? sec_stamp_reg : best_stamp_reg;
    assign c_age   = now_reg - c_stamp;
    assign occ_after = occ_reg;
    assign c_evict = c_valid && ((32'(occ_after) > 32'(max_ent_reg)) ||
                     (!c_age[31] && (c_age > {16'd0, max_age_reg})));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            idx_reg      <= '0;
            pend_reg     <= 1'b0;
            now_reg      <= '0;
            occ_reg      <= '0;
            max_ent_reg  <= MAX_ENTRIES_RST;
            max_age_reg  <= MAX_AGE_RST;
            out_full_reg <= 1'b0;
            match_reg    <= 1'b0;
            free_reg     <= 1'b0;
            best_reg     <= 1'b0;
            op_reg       <= OP_DUP;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_idx == REG_MAX_ENTRIES) max_ent_reg <= cfg_data[7:0];
                else                            max_age_reg <= cfg_data;
            end
            if (out_full_reg && !out_stall)
                out_full_reg <= 1'b0;
            if (cmd.load)
            begin
                op_reg  <= req_type;
                key_reg <= req_id;
                shr_reg <= share_in[SHARE_BITS-1:0];
            end
            if (cmd.tick)
                now_reg <= now_reg + 32'd1;
            if (cmd.scan_start)
            begin
                idx_reg   <= '0;
                pend_reg  <= 1'b0;
                match_reg <= 1'b0;
                free_reg  <= 1'b0;
                best_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if (idx_reg != (AW+1)'(TABLE_DEPTH))
                    idx_reg <= idx_reg + 1'b1;
                pend_reg <= 1'b1;
                if (pend_reg && rd_valid)
                begin
                    if (!match_reg && ((op_reg == OP_DUP) ? (rd_share == shr_reg)
                                                          : (rd_key == key_reg)))
                    begin
                        match_reg     <= 1'b1;
                        match_idx_reg <= rd_idx;
                        mshare_reg    <= rd_share;
                        mstamp_reg    <= rd_stamp;
                    end
                    // smallest id, signed order; first occurrence wins ties
                    if (!best_reg || ($signed(rd_key) < $signed(best_key_reg)))
                    begin
                        best_reg       <= 1'b1;
                        best_idx_reg   <= rd_idx;
                        best_key_reg   <= rd_key;
                        best_stamp_reg <= rd_stamp;
                    end
                end
                if (pend_reg && !rd_valid && !free_reg)
                begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx;
                end
            end
            if (cmd.clean_eval && c_evict)
            begin
                valid_reg[c_idx] <= 1'b0;
                occ_reg <= occ_reg - 1'b1;
            end
            if (cmd.ins_commit && !match_reg && free_reg)
            begin
                valid_reg[free_idx_reg] <= 1'b1;
                occ_reg <= occ_reg + 1'b1;
            end
            if (cmd.rem_commit && match_reg)
            begin
                valid_reg[match_idx_reg] <= 1'b0;
                occ_reg <= occ_reg - 1'b1;
                // the removed entry may be the smallest id: rescan is avoided by
                // dropping it from the cleanup candidate
                if (best_idx_reg == match_idx_reg)
                    best_reg <= 1'b0;
            end
            if (cmd.res_load)
                out_full_reg <= 1'b1;
        end
    end

    // (second-smallest tracked in parallel with best)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sec_reg <= 1'b0;
        else if (cmd.scan_start)
            sec_reg <= 1'b0;
        else if (cmd.scan_step && pend_reg && rd_valid)
        begin
            if (!best_reg || ($signed(rd_key) < $signed(best_key_reg)))
            begin
                sec_reg       <= best_reg;
                sec_idx_reg   <= best_idx_reg;
                sec_key_reg   <= best_key_reg;
                sec_stamp_reg <= best_stamp_reg;
            end
            else if (!sec_reg || ($signed(rd_key) < $signed(sec_key_reg)))
            begin
                sec_reg       <= 1'b1;
                sec_idx_reg   <= rd_idx;
                sec_key_reg   <= rd_key;
                sec_stamp_reg <= rd_stamp;
            end
        end
    end

    // remove of the smallest id promotes the runner-up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rem_best <= 1'b0;
        else if (cmd.load)
            rem_best <= 1'b0;
        else if (cmd.rem_commit)
            rem_best <= match_reg && best_reg && (best_idx_reg == match_idx_reg);
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            hit         <= ((op_reg == OP_DUP) || (op_reg == OP_LOOKUP)) && match_reg;
            share_out   <= (op_reg == OP_LOOKUP && match_reg) ? 64'(mshare_reg) : 64'd0;
            age_sec     <= (op_reg == OP_LOOKUP && match_reg) ? (now_reg - mstamp_reg) : 32'd0;
            entry_count <= 9'(occ_reg);
        end
    end

    assign out_valid = out_full_reg;
endmodule
`default_nettype wire

// File: hw/rtl/outstanding_request_table_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// outstanding_request_table_top
// Table of outstanding requests with serial scan and one cleanup step.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries req_type, req_id, share_in; a
//   transaction is taken when in_valid is high and in_stall low.
//   Output channel out_valid/out_stall returns hit, share_out, age_sec and
//   entry_count, one result transaction per input transaction.
//   cfg_valid/cfg_ready writes max_entries (index 0) or max_age (index 1);
//   write only while the block is idle.
// Sequence: the entry memory is scanned serially through its single read port.
//   Duplicate check runs one scan pass and a commit step; remove and lookup
//   add a cleanup step after the commit; record runs a cleanup scan and a
//   cleanup step before its scan and commit; tick and unused codes go straight
//   to the result step. One transaction is in work at a time; in_stall stays
//   high until its result is loaded into the output register, and the next
//   transaction is taken in the following cycle at the earliest.
// Reset: valid bits, counters and occupancy clear at once; no clearing pass.
// A stalled result holds in the output register; the next input is taken
//   while it waits, and its result loads once the old one is taken.
// ----------------------------------------------------------------------------
module outstanding_request_table_top #(
    parameter int TABLE_DEPTH = ort_pkg::DEF_TABLE_DEPTH,
    parameter int SHARE_BITS  = ort_pkg::DEF_SHARE_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [2:0]        req_type,
    input  wire logic signed [31:0] req_id,
    input  wire logic [63:0]       share_in,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   hit,
    output logic [63:0]            share_out,
    output logic signed [31:0]     age_sec,
    output logic [8:0]             entry_count,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [15:0]       cfg_data
);
    import ort_pkg::*;

    ort_cmd_t cmd;
    ort_sts_t sts;
    logic     busy;
    logic     in_acc;

    // hold off new transactions while one is in work
    assign in_stall  = busy;
    assign in_acc    = in_valid && !busy;
    assign cfg_ready = 1'b1;

    ort_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_acc   (in_acc),
        .req_type (req_type),
        .sts      (sts),
        .busy     (busy),
        .cmd      (cmd)
    );

    ort_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .SHARE_BITS  (SHARE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .req_type    (req_type),
        .req_id      (req_id),
        .share_in    (share_in),
        .cfg_we      (cfg_valid),
        .cfg_idx     (cfg_index),
        .cfg_data    (cfg_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .share_out   (share_out),
        .age_sec     (age_sec),
        .entry_count (entry_count)
    );
endmodule
`default_nettype wire

// File: hw/rtl/ort_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ort_checker
// Port-level checks on the outstanding request table.
// ----------------------------------------------------------------------------
module ort_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic        hit,
    input wire logic [63:0] share_out,
    input wire logic [8:0]  entry_count
);
    // busy right after an accepted transaction
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("no stall after accept");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(share_out)))
        else $error("stalled result changed");

    a_share: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !hit) |-> (share_out == 64'd0))
        else $error("share without hit");

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (entry_count <= 9'd256))
        else $error("count out of range");
endmodule

bind outstanding_request_table_top ort_checker u_ort_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .hit         (hit),
    .share_out   (share_out),
    .entry_count (entry_count)
);
`default_nettype wire
